>>> hdl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> hdl/qoid_pkg.sv
package qoid_pkg;

	localparam int HASH_ENTRIES = 64;
	localparam int HASH_AW      = $clog2(HASH_ENTRIES);
	localparam int RUN_W        = 6;
	localparam int LEFT_W       = 24;
	localparam int CFG_IDX_W    = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXELS     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BGR        = 2'd2;

	// Opcode classes (top two bits of a byte)
	localparam logic [1:0] OP_INDEX = 2'b00;
	localparam logic [1:0] OP_DIFF  = 2'b01;
	localparam logic [1:0] OP_LUMA  = 2'b10;
	localparam logic [1:0] OP_WIDE  = 2'b11;

	localparam logic [7:0] BYTE_BACKGROUND = 8'hFF;
	localparam logic [7:0] BYTE_LITERAL    = 8'hFE;

	typedef struct packed {
		logic [7:0] stream_byte;
		logic       image_start;
	} byte_beat_t;

	typedef struct packed {
		logic [15:0] pixel;
		logic        last_pixel;
	} pix_beat_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		logic [15:0]       background_color;
		logic [LEFT_W-1:0] pixels_per_image;
		logic              bgr_order;
	} cfg_t;

	typedef struct packed {
		logic               en;
		logic [HASH_AW-1:0] addr;
		rgb_t               data;
	} hash_wr_t;

	typedef struct packed {
		logic             load;
		logic [15:0]      pixel;
		logic [RUN_W-1:0] count;
		logic             last;
	} pix_load_t;

	// Green and the low channel are ORed unmasked, so either can spill upward.
	function automatic logic [15:0] pack565(input rgb_t c, input logic bgr);
		logic [7:0] hi;
		logic [7:0] lo;
		hi = bgr ? c.b : c.r;
		lo = bgr ? c.r : c.b;
		return {hi[4:0], 11'd0} | {3'd0, c.g, 5'd0} | {8'd0, lo};
	endfunction

endpackage

>>> hdl/qoid_hash_mem.sv
module qoid_hash_mem (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [qoid_pkg::HASH_AW-1:0] wr_addr,
	input  qoid_pkg::rgb_t             wr_data,
	input  logic                       rd_en,
	input  logic [qoid_pkg::HASH_AW-1:0] rd_addr,
	output qoid_pkg::rgb_t             rd_data
);
	import qoid_pkg::*;

	rgb_t                    mem [HASH_ENTRIES];
	logic [HASH_ENTRIES-1:0] valid_q;
	rgb_t                    raw_q;
	rgb_t                    byp_data_q;
	logic                    raw_valid_q;
	logic                    byp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			raw_q      <= mem[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	// Entries never written read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			raw_valid_q <= 1'b0;
			byp_q       <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				raw_valid_q <= valid_q[rd_addr];
				byp_q       <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	assign rd_data = byp_q ? byp_data_q : (raw_valid_q ? raw_q : '0);

endmodule

>>> hdl/qoid_decode.sv
module qoid_decode (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  qoid_pkg::byte_beat_t  item,
	input  qoid_pkg::cfg_t        cfg,
	input  qoid_pkg::rgb_t        hash_entry,
	input  logic                  out_free,
	output logic                  consume,
	output qoid_pkg::hash_wr_t    hash_wr,
	output qoid_pkg::pix_load_t   pix_load
);
	import qoid_pkg::*;

	typedef enum logic [3:0] {
		PEND_NONE   = 4'b0001,
		PEND_LUMA   = 4'b0010,
		PEND_LIT_HI = 4'b0100,
		PEND_LIT_LO = 4'b1000
	} pend_t;

	rgb_t              color_q;
	pend_t             pend_q;
	logic [7:0]        held_q;
	logic [LEFT_W-1:0] left_q;

	rgb_t              base_color;
	pend_t             base_pend;
	logic [LEFT_W-1:0] base_left;
	rgb_t              nxt_color;
	pend_t             nxt_pend;
	logic [7:0]        nxt_held;
	logic [LEFT_W-1:0] nxt_left;
	logic              emit_hashed;
	logic              emit_bg;
	logic              emit_run;
	logic              produce;
	logic [7:0]        vg;
	logic [6:0]        run_len;
	logic [RUN_W-1:0]  count;
	logic [HASH_AW-1:0] slot;
	logic [7:0]        b;

	assign b = item.stream_byte;

	always_comb begin
		base_color  = item.image_start ? '0 : color_q;
		base_left   = item.image_start ? cfg.pixels_per_image : left_q;
		base_pend   = item.image_start ? PEND_NONE : pend_q;
		nxt_color   = base_color;
		nxt_pend    = base_pend;
		nxt_held    = held_q;
		emit_hashed = 1'b0;
		emit_bg     = 1'b0;
		emit_run    = 1'b0;
		vg          = {2'd0, held_q[5:0]} - 8'd32;
		run_len     = {1'b0, b[5:0]} + 7'd1;
		if (base_left != '0) begin
			case (base_pend)
				PEND_LUMA: begin
					nxt_pend    = PEND_NONE;
					nxt_color.r = base_color.r + vg - 8'd8 + {4'd0, b[7:4]};
					nxt_color.g = base_color.g + vg;
					nxt_color.b = base_color.b + vg - 8'd8 + {4'd0, b[3:0]};
					emit_hashed = 1'b1;
				end
				PEND_LIT_HI: begin
					nxt_held = b;
					nxt_pend = PEND_LIT_LO;
				end
				PEND_LIT_LO: begin
					nxt_pend    = PEND_NONE;
					nxt_color.r = {3'd0, held_q[7:3]};
					nxt_color.g = {2'd0, held_q[2:0], b[7:5]};
					nxt_color.b = {3'd0, b[4:0]};
					emit_hashed = 1'b1;
				end
				PEND_NONE: begin
					case (b[7:6])
						OP_INDEX: begin
							nxt_color   = hash_entry;
							emit_hashed = 1'b1;
						end
						OP_DIFF: begin
							nxt_color.r = base_color.r + {6'd0, b[5:4]} - 8'd2;
							nxt_color.g = base_color.g + {6'd0, b[3:2]} - 8'd2;
							nxt_color.b = base_color.b + {6'd0, b[1:0]} - 8'd2;
							emit_hashed = 1'b1;
						end
						OP_LUMA: begin
							nxt_held = b;
							nxt_pend = PEND_LUMA;
						end
						default: begin
							if (b == BYTE_BACKGROUND) begin
								emit_bg = 1'b1;
							end else if (b == BYTE_LITERAL) begin
								nxt_pend = PEND_LIT_HI;
							end else begin
								emit_run = 1'b1;
							end
						end
					endcase
				end
				default: begin
					nxt_pend = PEND_NONE;
				end
			endcase
		end
		produce = emit_hashed || emit_bg || emit_run;
		// Cut a run at the pixels still owed to the image.
		if (!emit_run) begin
			count = RUN_W'(1);
		end else if (base_left < {{(LEFT_W-7){1'b0}}, run_len}) begin
			count = base_left[RUN_W-1:0];
		end else begin
			count = run_len[RUN_W-1:0];
		end
		nxt_left = produce ? base_left - {{(LEFT_W-RUN_W){1'b0}}, count} : base_left;
		slot     = (nxt_color.r[5:0] * 6'd3) + (nxt_color.g[5:0] * 6'd5)
			+ (nxt_color.b[5:0] * 6'd7);
	end

	assign consume = item_valid && (!produce || out_free);

	assign hash_wr.en   = consume && emit_hashed;
	assign hash_wr.addr = slot;
	assign hash_wr.data = nxt_color;

	assign pix_load.load  = consume && produce;
	assign pix_load.pixel = emit_bg ? cfg.background_color : pack565(nxt_color, cfg.bgr_order);
	assign pix_load.count = count;
	assign pix_load.last  = (nxt_left == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= '0;
			pend_q  <= PEND_NONE;
			held_q  <= '0;
			left_q  <= '0;
		end else if (consume) begin
			color_q <= nxt_color;
			pend_q  <= nxt_pend;
			held_q  <= nxt_held;
			left_q  <= nxt_left;
		end
	end

endmodule

>>> hdl/qoid_pix_out.sv
module qoid_pix_out (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qoid_pkg::pix_load_t  pix_load,
	input  logic                 pix_stall,
	output logic                 pix_valid,
	output qoid_pkg::pix_beat_t  pix_data,
	output logic                 out_free
);
	import qoid_pkg::*;

	logic [15:0]      pix_q;
	logic [RUN_W-1:0] rep_q;
	logic             last_q;

	assign pix_valid           = (rep_q != '0);
	assign pix_data.pixel      = pix_q;
	assign pix_data.last_pixel = last_q && (rep_q == RUN_W'(1));
	assign out_free            = !pix_valid || (!pix_stall && (rep_q == RUN_W'(1)));

	always_ff @(posedge clk) begin
		if (pix_load.load) begin
			pix_q <= pix_load.pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_q  <= '0;
			last_q <= 1'b0;
		end else if (pix_load.load) begin
			rep_q  <= pix_load.count;
			last_q <= pix_load.last;
		end else if (pix_valid && !pix_stall) begin
			rep_q <= rep_q - RUN_W'(1);
		end
	end

endmodule

>>> hdl/qoi_rgb565_image_decoder_unit.sv
// QOI-style RGB565 image decoder.
//
// Byte channel (byte_valid/byte_stall/byte_data): one compressed byte per beat;
// set image_start on the first byte of each image. The beat is taken at an edge
// with valid high and stall low.
// Pixel channel (pix_valid/pix_stall/pix_data): one RGB565 pixel per beat,
// last_pixel marks the final pixel of the image.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
// only while the decoder is idle. Indexes: background, pixel count, BGR order.
// A byte beat passes through the input register, then decode loads the output
// register, from which the pixel shows on the pixel channel. Throughput: one
// byte per cycle while the pixel channel does not stall; a run holds the byte
// channel because the output register repeats one pixel per beat.
// Reset clears color, pending opcode, pixel count and all hash entries at once
// (a valid bit per entry), so decoding needs no clearing pass after reset.
// A stalled pixel beat holds; the input register takes bytes until it holds one
// that makes a pixel, then holds byte_stall high until the output frees up.
module qoi_rgb565_image_decoder_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              byte_valid,
	output logic                              byte_stall,
	input  qoid_pkg::byte_beat_t              byte_data,
	output logic                              pix_valid,
	input  logic                              pix_stall,
	output qoid_pkg::pix_beat_t               pix_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [qoid_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [qoid_pkg::LEFT_W-1:0]       cfg_data
);
	import qoid_pkg::*;

	cfg_t       cfg_q;
	logic       valid_s1;
	byte_beat_t item_s1;
	logic       byte_accept;
	logic       consume;
	logic       out_free;
	rgb_t       hash_entry;
	hash_wr_t   hash_wr;
	pix_load_t  pix_load;

	assign cfg_ready = 1'b1;

	// Register writes; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BACKGROUND: cfg_q.background_color <= cfg_data[15:0];
				CFG_PIXELS:     cfg_q.pixels_per_image <= cfg_data;
				CFG_BGR:        cfg_q.bgr_order        <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Input register: hold the byte until the decoder consumes it.
	assign byte_stall  = valid_s1 && !consume;
	assign byte_accept = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_accept) begin
			item_s1 <= byte_data;
		end
	end

	// Hash lookup runs alongside the input register, addressed by the low six
	// bits of the incoming byte; only INDEX uses the result.
	qoid_hash_mem u_hash (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (hash_wr.en),
		.wr_addr (hash_wr.addr),
		.wr_data (hash_wr.data),
		.rd_en   (byte_accept),
		.rd_addr (byte_data.stream_byte[HASH_AW-1:0]),
		.rd_data (hash_entry)
	);

	qoid_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item       (item_s1),
		.cfg        (cfg_q),
		.hash_entry (hash_entry),
		.out_free   (out_free),
		.consume    (consume),
		.hash_wr    (hash_wr),
		.pix_load   (pix_load)
	);

	qoid_pix_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_load  (pix_load),
		.pix_stall (pix_stall),
		.pix_valid (pix_valid),
		.pix_data  (pix_data),
		.out_free  (out_free)
	);

endmodule

>>> hdl/qoid_checker.sv
`include "assert_macros.svh"

module qoid_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 byte_valid,
	input logic                 byte_stall,
	input qoid_pkg::byte_beat_t byte_data,
	input logic                 pix_valid,
	input logic                 pix_stall,
	input qoid_pkg::pix_beat_t  pix_data,
	input logic                 cfg_valid,
	input logic                 cfg_ready
);
	import qoid_pkg::*;

	logic byte_taken;

	assign byte_taken = byte_valid && !byte_stall;

	// A stalled pixel beat holds.
	`ASSERT_NEXT(a_pix_hold, clk, arst_n, pix_valid && pix_stall, pix_valid && $stable(pix_data))

	// The config port never back-pressures.
	`ASSERT_SAME(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready)

	// Stall only rises once a byte has been taken into the input register.
	`ASSERT_SAME(a_stall_rise, clk, arst_n, $rose(byte_stall), $past(byte_taken))

	// A stalled byte beat holds.
	`ASSERT_NEXT(a_byte_hold, clk, arst_n, byte_valid && byte_stall, byte_valid && $stable(byte_data))

endmodule

bind qoi_rgb565_image_decoder_unit qoid_checker u_qoid_checker (.*);
